[sv/differential_drive_ramp_controller_defines.svh]
// Assertion macros used by the checker of the ramp controller.
// No dependencies; include once per file that asserts.
`ifndef DIFFERENTIAL_DRIVE_RAMP_CONTROLLER_DEFINES_SVH
`define DIFFERENTIAL_DRIVE_RAMP_CONTROLLER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define DDRC_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define DDRC_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

[sv/ddrc_pkg.sv]
// Types and constants for the differential drive ramp controller.
// No dependencies.
`timescale 1ns / 1ps

package ddrc_pkg;

	localparam int SPEED_W  = 8;
	localparam int MAG_W    = 7;
	localparam int PERIOD_W = 16;
	localparam int PROD_W   = PERIOD_W + MAG_W;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [MAG_W-1:0] SPEED_MAX = 7'd100;

	// floor(p / 100) == (p * RECIP_100) >> RECIP_SHIFT for every p below 2^PROD_W
	localparam int RECIP_W = 24;
	localparam int RECIP_SHIFT = 30;
	localparam logic [RECIP_W-1:0] RECIP_100 = 24'd10737419;

	// Item kinds
	localparam logic [1:0] KIND_BUTTON = 2'd0;
	localparam logic [1:0] KIND_RAMP   = 2'd1;
	localparam logic [1:0] KIND_ESTOP  = 2'd2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FULL_SPEED = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RAMP_UP    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RAMP_DOWN  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PWM_PERIOD = 3'd3;

	// Register reset values
	localparam logic [MAG_W-1:0]    FULL_SPEED_RST = 7'd100;
	localparam logic [MAG_W-1:0]    RAMP_UP_RST    = 7'd2;
	localparam logic [MAG_W-1:0]    RAMP_DOWN_RST  = 7'd5;
	localparam logic [PERIOD_W-1:0] PWM_PERIOD_RST = 16'd999;

	typedef struct packed {
		logic [1:0] kind;
		logic       forward_pressed;
		logic       backward_pressed;
		logic       left_pressed;
		logic       right_pressed;
		logic       stop_pressed;
	} item_t;

	typedef struct packed {
		logic [PERIOD_W-1:0]       left_duty;
		logic                      left_forward;
		logic [PERIOD_W-1:0]       right_duty;
		logic                      right_forward;
		logic signed [SPEED_W-1:0] left_speed_now;
		logic signed [SPEED_W-1:0] right_speed_now;
	} result_t;

endpackage

[sv/differential_drive_ramp_controller.sv]
// Top level of the differential drive ramp controller: goal setting, ramping
// and duty scaling in a four-register pipeline. Depends on ddrc_pkg.
//
//  channel  | signals                              | transaction
//  ---------+--------------------------------------+---------------------------
//  item     | item_valid, item_stall, item         | valid & !stall
//  result   | result_valid, result_stall, result   | valid & !stall
//  cfg      | cfg_valid, cfg_ready, cfg_index/data | valid & ready (ready is 1)
//
// One item per cycle unless result_stall backs the pipeline up to stage 1. A ramp
// tick or emergency stop updates goals and speeds in stage 1, and the two multiplies
// (period * |speed|, then the reciprocal of 100) are registered into stages 3 and 4,
// where the result shows. Button samples leave stage 1 without entering the later stages.
// result_stall reaches item_stall through the stage enables in the same cycle, so
// empty stages still take items. Reset restores register defaults and clears
// goals, speeds and valid bits.
`timescale 1ns / 1ps

module differential_drive_ramp_controller
	import ddrc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_stall,
	input  item_t                 item,
	output logic                  result_valid,
	input  logic                  result_stall,
	output result_t               result,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// Move one speed toward its goal, stopping exactly at the goal
	function automatic logic signed [SPEED_W-1:0] ramp_toward(
		input logic signed [SPEED_W-1:0] now,
		input logic signed [SPEED_W-1:0] goal,
		input logic [MAG_W-1:0]          up,
		input logic [MAG_W-1:0]          dn
	);
		logic signed [SPEED_W:0] n9;
		logic signed [SPEED_W:0] g9;
		logic signed [SPEED_W:0] sum;
		n9 = {now[SPEED_W-1], now};
		g9 = {goal[SPEED_W-1], goal};
		if (n9 < g9) begin
			sum = n9 + $signed({2'b00, up});
			if (sum > g9) sum = g9;
		end else if (n9 > g9) begin
			sum = n9 - $signed({2'b00, dn});
			if (sum < g9) sum = g9;
		end else begin
			sum = n9;
		end
		return sum[SPEED_W-1:0];
	endfunction

	function automatic logic [MAG_W-1:0] magnitude(input logic signed [SPEED_W-1:0] s);
		logic signed [SPEED_W-1:0] a;
		a = s[SPEED_W-1] ? -s : s;
		return a[MAG_W-1:0];
	endfunction

	// Configuration registers
	logic [MAG_W-1:0]    full_speed_q;
	logic [MAG_W-1:0]    ramp_up_q;
	logic [MAG_W-1:0]    ramp_down_q;
	logic [PERIOD_W-1:0] period_q;

	// Speed state
	logic signed [SPEED_W-1:0] left_goal_q, right_goal_q;
	logic signed [SPEED_W-1:0] left_actual_q, right_actual_q;

	// Pipeline registers
	logic  v_s1, v_s2, v_s3, v_s4;
	item_t item_s1;
	logic signed [SPEED_W-1:0] l_spd_s2, r_spd_s2, l_spd_s3, r_spd_s3;
	logic [MAG_W-1:0]          l_mag_s2, r_mag_s2;
	logic [PROD_W-1:0]         l_prod_s3, r_prod_s3;
	result_t                   res_s4;

	// Stage control
	logic en_s1, en_s2, en_s3, en_s4;
	logic res_s1, adv_s1;

	// Next state from stage 1
	logic signed [SPEED_W-1:0] l_goal_d, r_goal_d, l_act_d, r_act_d;

	// Scaling
	logic [PROD_W+RECIP_W-1:0] l_quot, r_quot;

	assign cfg_ready = 1'b1;

	// Take register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_speed_q <= FULL_SPEED_RST;
			ramp_up_q    <= RAMP_UP_RST;
			ramp_down_q  <= RAMP_DOWN_RST;
			period_q     <= PWM_PERIOD_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_FULL_SPEED: full_speed_q <= cfg_data[MAG_W-1:0];
				REG_RAMP_UP:    ramp_up_q    <= cfg_data[MAG_W-1:0];
				REG_RAMP_DOWN:  ramp_down_q  <= cfg_data[MAG_W-1:0];
				REG_PWM_PERIOD: period_q     <= cfg_data[PERIOD_W-1:0];
				default: ;
			endcase
		end
	end

	// Stall chain: a stage loads when empty or when its content moves on
	assign res_s1 = (item_s1.kind == KIND_RAMP) || (item_s1.kind == KIND_ESTOP);
	assign en_s4  = !v_s4 || !result_stall;
	assign en_s3  = !v_s3 || en_s4;
	assign en_s2  = !v_s2 || en_s3;
	assign adv_s1 = v_s1 && (!res_s1 || en_s2);
	assign en_s1  = !v_s1 || adv_s1;
	assign item_stall = !en_s1;

	// Work out new goals and speeds for the item in stage 1
	always_comb begin
		logic [MAG_W-1:0]          full7;
		logic signed [SPEED_W-1:0] full8;
		logic signed [SPEED_W-1:0] half8;
		logic fwd, back, tl, tr;
		full7 = (full_speed_q > SPEED_MAX) ? SPEED_MAX : full_speed_q;
		full8 = $signed({1'b0, full7});
		half8 = $signed({2'b00, full7[MAG_W-1:1]});
		fwd = item_s1.forward_pressed && !item_s1.backward_pressed;
		back = item_s1.backward_pressed && !item_s1.forward_pressed;
		tl = item_s1.left_pressed && !item_s1.right_pressed;
		tr = item_s1.right_pressed && !item_s1.left_pressed;
		l_goal_d = left_goal_q;
		r_goal_d = right_goal_q;
		l_act_d  = left_actual_q;
		r_act_d  = right_actual_q;
		case (item_s1.kind)
			KIND_BUTTON: begin
				if (item_s1.stop_pressed) begin
					l_goal_d = '0;
					r_goal_d = '0;
				end else if (fwd) begin
					l_goal_d = tl ? half8 : full8;
					r_goal_d = tr ? half8 : full8;
				end else if (back) begin
					l_goal_d = tl ? -half8 : -full8;
					r_goal_d = tr ? -half8 : -full8;
				end else if (tl) begin
					l_goal_d = -half8;
					r_goal_d = half8;
				end else if (tr) begin
					l_goal_d = half8;
					r_goal_d = -half8;
				end else begin
					l_goal_d = '0;
					r_goal_d = '0;
				end
			end
			KIND_RAMP: begin
				l_act_d = ramp_toward(left_actual_q, left_goal_q, ramp_up_q, ramp_down_q);
				r_act_d = ramp_toward(right_actual_q, right_goal_q, ramp_up_q, ramp_down_q);
			end
			KIND_ESTOP: begin
				l_goal_d = '0;
				r_goal_d = '0;
				l_act_d  = '0;
				r_act_d  = '0;
			end
			default: ;
		endcase
	end

	// Commit state when the stage 1 item moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_goal_q    <= '0;
			right_goal_q   <= '0;
			left_actual_q  <= '0;
			right_actual_q <= '0;
		end else if (adv_s1) begin
			left_goal_q    <= l_goal_d;
			right_goal_q   <= r_goal_d;
			left_actual_q  <= l_act_d;
			right_actual_q <= r_act_d;
		end
	end

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= item_valid;
			if (en_s2) v_s2 <= adv_s1 && res_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
		end
	end

	// Reciprocal multiply for the divide by 100
	assign l_quot = l_prod_s3 * RECIP_100;
	assign r_quot = r_prod_s3 * RECIP_100;

	// Payload: capture item, speeds, products, then the result
	always_ff @(posedge clk) begin
		if (en_s1) item_s1 <= item;
		if (en_s2) begin
			l_spd_s2 <= l_act_d;
			r_spd_s2 <= r_act_d;
			l_mag_s2 <= magnitude(l_act_d);
			r_mag_s2 <= magnitude(r_act_d);
		end
		if (en_s3) begin
			l_spd_s3  <= l_spd_s2;
			r_spd_s3  <= r_spd_s2;
			l_prod_s3 <= period_q * l_mag_s2;
			r_prod_s3 <= period_q * r_mag_s2;
		end
		if (en_s4) begin
			res_s4.left_duty       <= l_quot[RECIP_SHIFT+PERIOD_W-1:RECIP_SHIFT];
			res_s4.right_duty      <= r_quot[RECIP_SHIFT+PERIOD_W-1:RECIP_SHIFT];
			res_s4.left_forward    <= !l_spd_s3[SPEED_W-1];
			res_s4.right_forward   <= !r_spd_s3[SPEED_W-1];
			res_s4.left_speed_now  <= l_spd_s3;
			res_s4.right_speed_now <= r_spd_s3;
		end
	end

	assign result_valid = v_s4;
	assign result       = res_s4;

endmodule

[sv/ddrc_checker.sv]
// Port-level checks for the differential drive ramp controller, bound to the
// top level. Depends on ddrc_pkg and the shared assertion macros.
`timescale 1ns / 1ps
`include "differential_drive_ramp_controller_defines.svh"

module ddrc_checker
	import ddrc_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    result_valid,
	input logic    result_stall,
	input result_t result
);

	logic dir_ok;
	logic any_zero;
	logic duty_ok;
	logic range_ok;

	// Direction follows the sign of the reported speed
	assign dir_ok = (result.left_forward == !result.left_speed_now[SPEED_W-1]) &&
		(result.right_forward == !result.right_speed_now[SPEED_W-1]);

	// Zero speed drives zero duty
	assign any_zero = (result.left_speed_now == 8'sd0) || (result.right_speed_now == 8'sd0);
	assign duty_ok = (result.left_speed_now != 8'sd0 || result.left_duty == 16'd0) &&
		(result.right_speed_now != 8'sd0 || result.right_duty == 16'd0);

	// Speeds stay within full scale
	assign range_ok = (result.left_speed_now >= -8'sd100) &&
		(result.left_speed_now <= 8'sd100) &&
		(result.right_speed_now >= -8'sd100) &&
		(result.right_speed_now <= 8'sd100);

	// Hold a stalled result transaction
	`DDRC_ASSERT_NXT(a_result_hold, result_valid && result_stall, result_valid && $stable(result))

	`DDRC_ASSERT_IMP(a_dir_sign, result_valid, dir_ok)

	`DDRC_ASSERT_IMP(a_zero_duty, result_valid && any_zero, duty_ok)

	`DDRC_ASSERT_IMP(a_speed_range, result_valid, range_ok)

endmodule

bind differential_drive_ramp_controller ddrc_checker u_ddrc_checker (.*);

[dv/ddrc_scoreboard_pkg.sv]
// Scoreboard for the differential drive ramp controller testbench: predicts
// each ramp tick and emergency stop and checks the results against it.
// Depends on ddrc_pkg.
`timescale 1ns / 1ps

package ddrc_scoreboard_pkg;
	import ddrc_pkg::*;

	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
	localparam int PERCENT = 100;
	localparam int PRINT_CAP = 50;

	class drive_scoreboard;
		int full_speed;
		int up_step;
		int down_step;
		int period;
		int left_goal;
		int right_goal;
		int left_cur;
		int right_cur;
		result_t awaited[$];
		int errors;

		function new();
			full_speed  = int'(FULL_SPEED_RST);
			up_step     = int'(RAMP_UP_RST);
			down_step   = int'(RAMP_DOWN_RST);
			period      = int'(PWM_PERIOD_RST);
			left_goal   = 0;
			right_goal  = 0;
			left_cur    = 0;
			right_cur   = 0;
			errors      = 0;
		endfunction

		function int pending();
			return awaited.size();
		endfunction

		// Mirror a register write; unknown indexes are dropped
		function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_FULL_SPEED: full_speed = int'(data[MAG_W-1:0]);
				REG_RAMP_UP:    up_step    = int'(data[MAG_W-1:0]);
				REG_RAMP_DOWN:  down_step  = int'(data[MAG_W-1:0]);
				REG_PWM_PERIOD: period     = int'(data[PERIOD_W-1:0]);
				default: ;
			endcase
		endfunction

		// Pick both targets from the buttons: stop, then drive, then pivot
		function void choose_goals(item_t it);
			int full;
			int base;
			bit turn_left;
			bit turn_right;
			full = (full_speed > PERCENT) ? PERCENT : full_speed;
			base = 0;
			turn_left  = it.left_pressed && !it.right_pressed;
			turn_right = it.right_pressed && !it.left_pressed;
			if (it.stop_pressed) begin
				left_goal  = 0;
				right_goal = 0;
				return;
			end
			if (it.forward_pressed && !it.backward_pressed) begin
				base = full;
			end else if (it.backward_pressed && !it.forward_pressed) begin
				base = -full;
			end
			if (base != 0) begin
				left_goal  = turn_left ? base / 2 : base;
				right_goal = turn_right ? base / 2 : base;
			end else if (turn_left) begin
				left_goal  = -(full / 2);
				right_goal = full / 2;
			end else if (turn_right) begin
				left_goal  = full / 2;
				right_goal = -(full / 2);
			end else begin
				left_goal  = 0;
				right_goal = 0;
			end
		endfunction

		// Move one speed toward its target without passing it
		function int slew(int now, int goal);
			if (now < goal) begin
				now += up_step;
				if (now > goal) now = goal;
			end else if (now > goal) begin
				now -= down_step;
				if (now < goal) now = goal;
			end
			return now;
		endfunction

		function logic [PERIOD_W-1:0] duty_of(int speed);
			int mag;
			mag = (speed < 0) ? -speed : speed;
			return PERIOD_W'((period * mag) / PERCENT);
		endfunction

		function result_t drive_outputs();
			result_t r;
			r.left_duty       = duty_of(left_cur);
			r.left_forward    = (left_cur >= 0);
			r.right_duty      = duty_of(right_cur);
			r.right_forward   = (right_cur >= 0);
			r.left_speed_now  = SPEED_W'(left_cur);
			r.right_speed_now = SPEED_W'(right_cur);
			return r;
		endfunction

		// Advance the prediction by one accepted input transaction
		function void note_item(item_t it);
			case (it.kind)
				KIND_BUTTON: choose_goals(it);
				KIND_RAMP: begin
					left_cur  = slew(left_cur, left_goal);
					right_cur = slew(right_cur, right_goal);
					awaited.push_back(drive_outputs());
				end
				KIND_ESTOP: begin
					left_goal  = 0;
					right_goal = 0;
					left_cur   = 0;
					right_cur  = 0;
					awaited.push_back(drive_outputs());
				end
				default: ;
			endcase
		endfunction

		task report(string msg);
			errors++;
			if (errors <= PRINT_CAP) $display("ERROR %0t: %s", $realtime, msg);
		endtask

		// Compare one result transaction with the oldest prediction
		task check_result(result_t got);
			result_t want;
			if (awaited.size() == 0) begin
				report($sformatf("result with none expected: duty %0d/%0d speed %0d/%0d",
					got.left_duty, got.right_duty, got.left_speed_now, got.right_speed_now));
				return;
			end
			want = awaited.pop_front();
			if (got.left_duty !== want.left_duty)
				report($sformatf("left_duty %0d, want %0d", got.left_duty, want.left_duty));
			if (got.left_forward !== want.left_forward)
				report($sformatf("left_forward %0b, want %0b", got.left_forward,
					want.left_forward));
			if (got.right_duty !== want.right_duty)
				report($sformatf("right_duty %0d, want %0d", got.right_duty, want.right_duty));
			if (got.right_forward !== want.right_forward)
				report($sformatf("right_forward %0b, want %0b", got.right_forward,
					want.right_forward));
			if (got.left_speed_now !== want.left_speed_now)
				report($sformatf("left_speed_now %0d, want %0d", got.left_speed_now,
					want.left_speed_now));
			if (got.right_speed_now !== want.right_speed_now)
				report($sformatf("right_speed_now %0d, want %0d", got.right_speed_now,
					want.right_speed_now));
		endtask
	endclass

endpackage

[dv/tb_differential_drive_ramp_controller.sv]
// Testbench top for the differential drive ramp controller: directed and
// random button, tick and stop traffic under several register settings.
// Depends on ddrc_pkg, ddrc_scoreboard_pkg and the controller RTL.
`timescale 1ns / 1ps

module tb_differential_drive_ramp_controller;
	import ddrc_pkg::*;
	import ddrc_scoreboard_pkg::*;

	localparam int PHASES = 12;
	localparam int ITEMS_PER_PHASE = 96;
	localparam int SQUEEZE_PHASE = 3;
	localparam int SQUEEZE_CYCLES = 80;
	localparam int SQUEEZE_ITEMS = 60;
	localparam int SETTLE_CYCLES = 8;
	localparam int IDLE_LIMIT = 1000;
	localparam int ITEM_W = $bits(item_t);

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  item_valid;
	logic                  item_stall;
	item_t                 item;
	logic                  result_valid;
	logic                  result_stall;
	result_t               result;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	bit src_quiet = 1'b0;
	bit sink_quiet = 1'b0;
	bit squeeze_req = 1'b0;
	int idle_cycles = 0;

	drive_scoreboard sb = new();

	differential_drive_ramp_controller u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #1 clk = ~clk;

	function automatic item_t make_item(logic [1:0] kind, bit fwd, bit back, bit lt, bit rt,
		bit stop);
		item_t it;
		it.kind             = kind;
		it.forward_pressed  = fwd;
		it.backward_pressed = back;
		it.left_pressed     = lt;
		it.right_pressed    = rt;
		it.stop_pressed     = stop;
		return it;
	endfunction

	// Mostly ticks and button samples; stops and the unused kind now and then
	function automatic item_t random_item();
		item_t it;
		int r;
		r = $urandom_range(0, 99);
		it = item_t'(ITEM_W'($urandom));
		if (r < 55) begin
			it.kind = KIND_RAMP;
		end else if (r < 90) begin
			it.kind = KIND_BUTTON;
		end else if (r < 95) begin
			it.kind = KIND_ESTOP;
		end else begin
			it.kind = KIND_UNUSED;
		end
		it.stop_pressed = ($urandom_range(0, 9) == 0);
		return it;
	endfunction

	function automatic int sender_gap();
		int r;
		if (src_quiet) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 50);
	endfunction

	// Offer one item, hold it until accepted, then log the transaction
	task automatic send_item(item_t it);
		int gap;
		gap = sender_gap();
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		do @(posedge clk); while (item_stall);
		sb.note_item(it);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.write_register(idx, data);
	endtask

	task automatic program_setting(logic [CFG_DATA_W-1:0] full, logic [CFG_DATA_W-1:0] up,
		logic [CFG_DATA_W-1:0] down, logic [CFG_DATA_W-1:0] period);
		write_reg(REG_FULL_SPEED, full);
		write_reg(REG_RAMP_UP, up);
		write_reg(REG_RAMP_DOWN, down);
		write_reg(REG_PWM_PERIOD, period);
		cfg_valid <= 1'b0;
	endtask

	// Wait out all predicted results, then let trailing button samples settle
	task automatic drain();
		item_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Check every result transaction
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) sb.check_result(result);
	end

	// Count cycles with no transaction on any channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
				(cfg_valid && cfg_ready)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("tb_differential_drive_ramp_controller failed");
				$finish;
			end
		end
	end

	// Receiver: random stalls, quiet stretches, and one long hold-off on request
	initial begin : sink
		int r;
		int run;
		bit hold;
		result_stall = 1'b0;
		@(posedge clk);
		forever begin
			if (squeeze_req) begin
				squeeze_req = 1'b0;
				hold = 1'b1;
				run = SQUEEZE_CYCLES;
			end else if (sink_quiet) begin
				hold = 1'b0;
				run = 1;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 50) begin
					hold = 1'b0;
					run = $urandom_range(1, 6);
				end else if (r < 90) begin
					hold = 1'b1;
					run = $urandom_range(1, 3);
				end else begin
					hold = 1'b1;
					run = $urandom_range(8, 30);
				end
			end
			result_stall <= hold;
			repeat (run) @(posedge clk);
		end
	end

	initial begin : stimulus
		int counted;
		int r;
		item_t it;
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: every button combination class, ticks, stop and unused kind
		send_item(make_item(KIND_RAMP, 0, 0, 0, 0, 0));
		send_item(make_item(KIND_UNUSED, 1, 1, 1, 1, 1));
		send_item(make_item(KIND_BUTTON, 1, 0, 0, 0, 0));
		repeat (3) send_item(make_item(KIND_RAMP, 0, 0, 0, 0, 0));
		send_item(make_item(KIND_BUTTON, 1, 0, 1, 0, 0));
		send_item(make_item(KIND_RAMP, 1, 1, 1, 1, 1));
		send_item(make_item(KIND_BUTTON, 0, 1, 0, 0, 0));
		repeat (2) send_item(make_item(KIND_RAMP, 0, 0, 0, 0, 0));
		send_item(make_item(KIND_BUTTON, 0, 1, 0, 1, 0));
		send_item(make_item(KIND_RAMP, 0, 0, 0, 0, 0));
		send_item(make_item(KIND_BUTTON, 0, 0, 1, 0, 0));
		send_item(make_item(KIND_RAMP, 0, 0, 0, 0, 0));
		send_item(make_item(KIND_BUTTON, 0, 0, 0, 1, 0));
		send_item(make_item(KIND_RAMP, 0, 0, 0, 0, 0));
		send_item(make_item(KIND_BUTTON, 1, 1, 1, 0, 0));
		send_item(make_item(KIND_BUTTON, 1, 0, 1, 1, 0));
		send_item(make_item(KIND_RAMP, 0, 0, 0, 0, 0));
		send_item(make_item(KIND_BUTTON, 1, 1, 1, 1, 1));
		send_item(make_item(KIND_RAMP, 0, 0, 0, 0, 0));
		send_item(make_item(KIND_ESTOP, 1, 1, 1, 1, 1));
		send_item(make_item(KIND_BUTTON, 0, 0, 0, 0, 0));
		send_item(make_item(KIND_RAMP, 0, 0, 0, 0, 0));
		drain();

		for (int p = 0; p < PHASES; p++) begin
			// Reprogram while idle: extremes first, then random settings
			case (p)
				0: ;
				1: begin
					write_reg(REG_SPARE, 16'h5A5A);
					program_setting(16'hFFFF, 16'd0, 16'd127, 16'hFFFF);
				end
				2: program_setting(16'd0, 16'd127, 16'd0, 16'd0);
				3: program_setting(16'd1, 16'd1, 16'd1, 16'd1);
				4: program_setting(16'd100, 16'hFF64, 16'h0064, 16'hFFFF);
				5: program_setting(16'd99, 16'd3, 16'd7, 16'd999);
				default: begin
					r = $urandom_range(0, 99);
					program_setting(
						($urandom_range(0, 9) == 0) ? CFG_DATA_W'($urandom_range(101, 127))
							: CFG_DATA_W'($urandom_range(0, 100)),
						($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom_range(0, 127))
							: CFG_DATA_W'($urandom_range(1, 12)),
						($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom_range(0, 127))
							: CFG_DATA_W'($urandom_range(1, 12)),
						(r < 10) ? 16'hFFFF : (r < 20) ? CFG_DATA_W'($urandom_range(0, 15))
							: CFG_DATA_W'($urandom_range(0, 65535)));
				end
			endcase
			if (p != 0) @(posedge clk);

			src_quiet = (p % 4 == 2);
			sink_quiet = (p % 4 == 2);

			// Hold the receiver off while items keep coming, so the pipe backs up
			if (p == SQUEEZE_PHASE) begin
				squeeze_req = 1'b1;
				src_quiet = 1'b1;
				for (int i = 0; i < SQUEEZE_ITEMS; i++) begin
					it = random_item();
					send_item(it);
				end
				src_quiet = 1'b0;
			end

			counted = 0;
			while (counted < ITEMS_PER_PHASE) begin
				it = random_item();
				send_item(it);
				if (it.kind != KIND_UNUSED) counted++;
			end
			drain();
		end

		if (sb.errors == 0) begin
			$display("tb_differential_drive_ramp_controller passed");
		end else begin
			$display("tb_differential_drive_ramp_controller failed");
		end
		$finish;
	end

endmodule

[sim.f]
+incdir+sv
sv/ddrc_pkg.sv
sv/differential_drive_ramp_controller.sv
sv/ddrc_checker.sv
dv/ddrc_scoreboard_pkg.sv
dv/tb_differential_drive_ramp_controller.sv
